// File: design/cidf_pkg.sv
package cidf_pkg;

    typedef enum logic [1:0] {
        OP_DECODE = 2'd0,
        OP_LOAD   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    localparam int ID_W        = 11;
    localparam int DATA_W      = 64;
    localparam int OFF_W       = 4;
    localparam int MASK_W      = 16;
    localparam int PKT_W       = 2;
    localparam int ROW_NUM_W   = 5;
    localparam int NUM_PACKETS = 3;

    // packet number that never fills a slot
    localparam logic [PKT_W-1:0] PKT_NONE = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   address;
        logic [OFF_W-1:0]  offset;
        logic [MASK_W-1:0] mask;
        logic [PKT_W-1:0]  packet;
    } entry_t;

endpackage

// File: design/cidf_table_ram.sv
module cidf_table_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [AW-1:0]           waddr,
    input  cidf_pkg::entry_t        wdata,
    input  logic                    re,
    input  logic [AW-1:0]           raddr,
    output cidf_pkg::entry_t        rdata
);

    cidf_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/cidf_hex_fmt.sv
module cidf_hex_fmt (
    input  logic [cidf_pkg::DATA_W-1:0] data,
    output logic [cidf_pkg::DATA_W-1:0] hex_first,
    output logic [cidf_pkg::DATA_W-1:0] hex_second
);

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'h0a)
        begin
            c = 8'h30 + {4'h0, n};
        end
        else
        begin
            c = 8'h41 + {4'h0, n} - 8'h0a;
        end
        return c;
    endfunction

    // byte b -> pair b%4 (hex_second if b>3), hi nibble first, pair 0 in 63:56
    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            hex_first[63-16*b -: 8]  = hex_char(data[8*b+4 +: 4]);
            hex_first[55-16*b -: 8]  = hex_char(data[8*b +: 4]);
            hex_second[63-16*b -: 8] = hex_char(data[8*(b+4)+4 +: 4]);
            hex_second[55-16*b -: 8] = hex_char(data[8*(b+4) +: 4]);
        end
    end

endmodule

// File: design/can_id_slot_filter_hex_formatter_core.sv
// Channel   Dir  tdata (low bit up)                                      tuser
// s_axis    in   can_id, frame_data, row_index, row_address, row_offset, opcode
//                row_position, row_packet, clear_packet, clear_bits
// m_axis    out  matched_row, packet_id, slot_offset, hex_first,         accepted,
//                hex_second                                              id_found
//
// Decode word: the table scan reads one row per cycle from the table RAM and stops
// at the first hit, or after the last row if no row hits.
// Load, clear and unused opcodes skip the scan and go from idle straight to finish.
// One word in flight at a time; s_axis_tready is high only while idle.
// The result waits in the output register; a stall there holds the block in finish.
// rst_n (async, low) invalidates every row and clears all filled bits.
module can_id_slot_filter_hex_formatter_core #(
    parameter int ROWS  = 32,
    parameter int SLOTS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // can_id[10:0], frame_data[74:11], row_index[79:75], row_address[90:80],
    // row_offset[94:91], row_position[110:95], row_packet[112:111],
    // clear_packet[114:113], clear_bits[130:115], zero[135:131]
    input  logic [135:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // matched_row[4:0], packet_id[6:5], slot_offset[10:7], hex_first[74:11],
    // hex_second[138:75], zero[143:139]
    output logic [143:0] m_axis_tdata,
    // accepted[0], id_found[1]
    output logic [1:0]   m_axis_tuser
);

    localparam int RowW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [RowW-1:0] LastRow = RowW'(ROWS - 1);
    localparam logic [cidf_pkg::MASK_W-1:0] SlotLimit =
        (SLOTS >= cidf_pkg::MASK_W) ? {cidf_pkg::MASK_W{1'b1}}
                                    : cidf_pkg::MASK_W'((33'd1 << SLOTS) - 33'd1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // input fields
    logic [cidf_pkg::ID_W-1:0]   in_can_id;
    logic [cidf_pkg::DATA_W-1:0] in_frame_data;
    logic [4:0]                  in_row_index;
    logic [cidf_pkg::ID_W-1:0]   in_row_address;
    logic [cidf_pkg::OFF_W-1:0]  in_row_offset;
    logic [cidf_pkg::MASK_W-1:0] in_row_position;
    logic [cidf_pkg::PKT_W-1:0]  in_row_packet;
    logic [cidf_pkg::PKT_W-1:0]  in_clear_packet;
    logic [cidf_pkg::MASK_W-1:0] in_clear_bits;
    cidf_pkg::opcode_t           in_opcode;

    assign in_can_id       = s_axis_tdata[10:0];
    assign in_frame_data   = s_axis_tdata[74:11];
    assign in_row_index    = s_axis_tdata[79:75];
    assign in_row_address  = s_axis_tdata[90:80];
    assign in_row_offset   = s_axis_tdata[94:91];
    assign in_row_position = s_axis_tdata[110:95];
    assign in_row_packet   = s_axis_tdata[112:111];
    assign in_clear_packet = s_axis_tdata[114:113];
    assign in_clear_bits   = s_axis_tdata[130:115];
    assign in_opcode       = cidf_pkg::opcode_t'(s_axis_tuser);

    state_t                      state_reg;
    cidf_pkg::opcode_t           op_reg;
    logic [cidf_pkg::ID_W-1:0]   id_reg;
    logic [cidf_pkg::DATA_W-1:0] data_reg;
    logic [ROWS-1:0]             valid_reg;
    logic [cidf_pkg::MASK_W-1:0] filled_reg [cidf_pkg::NUM_PACKETS];
    logic [RowW-1:0]             scan_ptr_reg;
    logic                        rd_pend_reg;
    logic [RowW-1:0]             rd_row_reg;
    logic                        rd_valid_reg;
    logic                        found_reg;
    logic [RowW-1:0]             hit_row_reg;
    cidf_pkg::entry_t            hit_entry_reg;
    logic                        m_valid_reg;
    logic [143:0]                m_data_reg;
    logic [1:0]                  m_user_reg;

    logic                        in_fire;
    logic                        load_we;
    cidf_pkg::entry_t            load_entry;
    cidf_pkg::entry_t            rd_entry;
    logic                        out_free;
    logic [cidf_pkg::MASK_W-1:0] hit_filled;
    logic                        take;
    logic [cidf_pkg::DATA_W-1:0] hex_first;
    logic [cidf_pkg::DATA_W-1:0] hex_second;
    logic [143:0]                res_data;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign load_we       = in_fire && (in_opcode == cidf_pkg::OP_LOAD)
                           && (int'(in_row_index) < ROWS);

    assign load_entry.address = in_row_address;
    assign load_entry.offset  = in_row_offset;
    assign load_entry.mask    = in_row_position & SlotLimit;
    assign load_entry.packet  = in_row_packet;

    // load only in idle, reads only in scan: the two ports never touch one row at once
    cidf_table_ram #(
        .DEPTH (ROWS),
        .AW    (RowW)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (RowW'(in_row_index)),
        .wdata (load_entry),
        .re    (state_reg == ST_SCAN),
        .raddr (scan_ptr_reg),
        .rdata (rd_entry)
    );

    cidf_hex_fmt u_hex (
        .data       (data_reg),
        .hex_first  (hex_first),
        .hex_second (hex_second)
    );

    always_comb
    begin
        case (hit_entry_reg.packet)
            2'd0:    hit_filled = filled_reg[0];
            2'd1:    hit_filled = filled_reg[1];
            2'd2:    hit_filled = filled_reg[2];
            default: hit_filled = '1;
        endcase
    end

    assign out_free = !m_valid_reg || m_axis_tready;
    assign take     = (op_reg == cidf_pkg::OP_DECODE) && found_reg
                      && (hit_entry_reg.packet != cidf_pkg::PKT_NONE)
                      && ((hit_filled & hit_entry_reg.mask) == '0);

    always_comb
    begin
        res_data = '0;
        if ((op_reg == cidf_pkg::OP_DECODE) && found_reg)
        begin
            res_data[4:0]  = cidf_pkg::ROW_NUM_W'(hit_row_reg);
            res_data[6:5]  = hit_entry_reg.packet;
            res_data[10:7] = hit_entry_reg.offset;
        end
        if (take)
        begin
            res_data[74:11]  = hex_first;
            res_data[138:75] = hex_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= cidf_pkg::OP_NONE;
            id_reg        <= '0;
            data_reg      <= '0;
            valid_reg     <= '0;
            for (int p = 0; p < cidf_pkg::NUM_PACKETS; p++)
            begin
                filled_reg[p] <= '0;
            end
            scan_ptr_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            rd_row_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            hit_row_reg   <= '0;
            hit_entry_reg <= '0;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
            m_user_reg    <= '0;
        end
        else
        begin
            // the row read in the previous cycle comes back with its row number and valid bit
            rd_pend_reg  <= (state_reg == ST_SCAN);
            rd_row_reg   <= scan_ptr_reg;
            rd_valid_reg <= valid_reg[scan_ptr_reg];

            if ((state_reg == ST_FINISH) && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        op_reg       <= in_opcode;
                        id_reg       <= in_can_id;
                        data_reg     <= in_frame_data;
                        found_reg    <= 1'b0;
                        scan_ptr_reg <= '0;
                        if (load_we)
                        begin
                            valid_reg[RowW'(in_row_index)] <= 1'b1;
                        end
                        if (in_opcode == cidf_pkg::OP_CLEAR)
                        begin
                            case (in_clear_packet)
                                2'd0:    filled_reg[0] <= filled_reg[0] & ~in_clear_bits;
                                2'd1:    filled_reg[1] <= filled_reg[1] & ~in_clear_bits;
                                2'd2:    filled_reg[2] <= filled_reg[2] & ~in_clear_bits;
                                default: ;
                            endcase
                        end
                        state_reg <= (in_opcode == cidf_pkg::OP_DECODE) ? ST_SCAN
                                                                         : ST_FINISH;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_ptr_reg != LastRow)
                    begin
                        scan_ptr_reg <= scan_ptr_reg + 1'b1;
                    end
                    if (rd_pend_reg)
                    begin
                        if (rd_valid_reg && (rd_entry.address == id_reg))
                        begin
                            found_reg     <= 1'b1;
                            hit_row_reg   <= rd_row_reg;
                            hit_entry_reg <= rd_entry;
                            state_reg     <= ST_FINISH;
                        end
                        else if (rd_row_reg == LastRow)
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        m_data_reg  <= res_data;
                        m_user_reg  <= {(op_reg == cidf_pkg::OP_DECODE) && found_reg, take};
                        if (take)
                        begin
                            case (hit_entry_reg.packet)
                                2'd0:    filled_reg[0] <= filled_reg[0] | hit_entry_reg.mask;
                                2'd1:    filled_reg[1] <= filled_reg[1] | hit_entry_reg.mask;
                                2'd2:    filled_reg[2] <= filled_reg[2] | hit_entry_reg.mask;
                                default: ;
                            endcase
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

`ifndef SYNTH
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken while one is in flight");

    a_accept_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1])
        else $error("frame accepted without a table hit");

    a_hex_zero_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[138:11] == '0))
        else $error("hex text present on a rejected frame");

    a_ptr_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> scan_ptr_reg <= LastRow)
        else $error("scan pointer beyond last row");

    a_miss_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |-> (m_axis_tdata[10:0] == '0))
        else $error("row fields set without a table hit");
`endif

endmodule
